### hdl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared sizes, codes and item types for the binary max-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int CAPACITY  = 64;
   localparam int KEY_WIDTH = 32;

   // store addressing and fill count
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   // child index 2*pos+2 before range checking
   localparam int IDX_W  = ADDR_W + 2;

   // item field widths
   localparam int KEY_FIELD_W   = 32;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 7;

   localparam logic MODE_PUSH    = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef logic [KEY_WIDTH-1:0] key_type;

   typedef struct packed {
      logic                   mode;
      logic [KEY_FIELD_W-1:0] key_in;
   } req_item_type;

   typedef struct packed {
      logic [KEY_FIELD_W-1:0]   extracted_key;
      logic [STATUS_W-1:0]      status;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic [KEY_FIELD_W-1:0]   top_key;
      logic                     top_valid;
   } rsp_item_type;

endpackage

### hdl/bmhq_if.sv
// ----------------------------------------------------------------------------
// bmhq_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface bmhq_req_if import bmhq_pkg::*; ();
   logic         valid;
   logic         ready;
   req_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

interface bmhq_rsp_if import bmhq_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_item_type item;

   modport source (output valid, output item, input ready);
   modport sink   (input valid, input item, output ready);
endinterface

### hdl/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bmhq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### hdl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Max-priority queue of up to CAPACITY keys kept as a binary heap in RAM.
//
// Channels: req_ch carries one item per operation (mode 0 pushes key_in,
// mode 1 extracts the maximum). rsp_ch returns one item per request with
// the removed key, a status code, the count held and the current top key.
// Sequence: a push reads the parent of the new slot on accept, then S_UP
// drops each smaller parent into the hole and moves the hole up until the
// key is placed. An extract reads the last entry on accept, S_LOAD makes it
// the value sinking from the root, and S_DOWN moves the larger child up
// until that value is placed. Full-heap pushes, empty-heap extracts and
// the extract of the last key go straight to S_FIN. At each level the
// sequencer compares the registered RAM read and, in the same cycle,
// writes one entry and launches the reads for the next level.
// Flow: one item at a time; req_ch.ready is high only while idle.
// Reset clears the state, fill count and output valid; the store needs no
// clearing since only entries below the count are ever used. If rsp_ch
// stalls, the finished result holds in the output register and the next
// request is still taken; its own result waits until the register frees up.
// ----------------------------------------------------------------------------
module binary_max_heap_queue import bmhq_pkg::*; (
   input logic          clock,
   input logic          reset,
   bmhq_req_if.sink     req_ch,
   bmhq_rsp_if.source   rsp_ch
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UP   = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_DOWN = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   key_type             key_ff, key_in;
   key_type             top_ff, top_in;
   key_type             taken_ff, taken_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_item_type        rsp_item_ff, rsp_item_in;

   logic                we;
   logic [ADDR_W-1:0]   waddr, ra_a, ra_b;
   key_type             wdata, rd_a, rd_b;

   logic                accept;
   logic [ADDR_W-1:0]   parent, grand;
   logic [IDX_W-1:0]    lc, rc;
   logic                l_take, r_take;
   key_type             best_val;
   logic [IDX_W-1:0]    best_idx;
   logic [IDX_W-1:0]    blc;
   logic [CNT_W-1:0]    n_after;
   logic                out_free;

   bmhq_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_WIDTH)) u_ram (
      .clock     (clock),
      .wr_en     (we),
      .wr_addr   (waddr),
      .wr_data   (wdata),
      .rd_addr_a (ra_a),
      .rd_data_a (rd_a),
      .rd_addr_b (ra_b),
      .rd_data_b (rd_b)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.item  = rsp_item_ff;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // sift-up addressing
   assign parent = ADDR_W'((pos_ff - ADDR_W'(1)) >> 1);
   assign grand  = ADDR_W'((parent - ADDR_W'(1)) >> 1);

   // sift-down: pick the larger child, ties go left
   assign lc       = IDX_W'({pos_ff, 1'b1});
   assign rc       = lc + IDX_W'(1);
   assign l_take   = (lc < IDX_W'(count_ff)) && (rd_a > key_ff);
   assign best_val = l_take ? rd_a : key_ff;
   assign r_take   = (rc < IDX_W'(count_ff)) && (rd_b > best_val);
   assign best_idx = r_take ? rc : lc;
   assign blc      = IDX_W'({best_idx[ADDR_W-1:0], 1'b1});
   assign n_after  = count_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      taken_in     = taken_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_item_in  = rsp_item_ff;
      we           = 1'b0;
      waddr        = pos_ff;
      wdata        = key_ff;
      ra_a         = '0;
      ra_b         = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               taken_in  = '0;
               status_in = STATUS_OK;
               if (req_ch.item.mode == MODE_PUSH) begin
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_FIN;
                  end else begin
                     key_in   = KEY_WIDTH'(req_ch.item.key_in);
                     pos_in   = count_ff[ADDR_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     ra_a     = ADDR_W'((count_ff[ADDR_W-1:0] - ADDR_W'(1)) >> 1);
                     state_in = S_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = S_FIN;
                  end else begin
                     taken_in = top_ff;
                     count_in = n_after;
                     ra_a     = n_after[ADDR_W-1:0];
                     state_in = (n_after == '0) ? S_FIN : S_LOAD;
                  end
               end
            end
         end
         S_UP: begin
            we = 1'b1;
            if (pos_ff != '0 && key_ff > rd_a) begin
               // parent drops into the hole, hole moves up
               wdata  = rd_a;
               pos_in = parent;
               ra_a   = grand;
            end else begin
               wdata    = key_ff;
               state_in = S_FIN;
            end
         end
         S_LOAD: begin
            // last entry becomes the value sinking from the root
            key_in   = rd_a;
            pos_in   = '0;
            ra_a     = ADDR_W'(1);
            ra_b     = ADDR_W'(2);
            state_in = S_DOWN;
         end
         S_DOWN: begin
            we = 1'b1;
            if (l_take || r_take) begin
               wdata  = best_val;
               if (r_take) begin
                  wdata = rd_b;
               end
               pos_in = best_idx[ADDR_W-1:0];
               ra_a   = blc[ADDR_W-1:0];
               ra_b   = ADDR_W'(blc + IDX_W'(1));
            end else begin
               wdata    = key_ff;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_item_in.extracted_key = KEY_FIELD_W'(taken_ff);
               rsp_item_in.status        = status_ff;
               rsp_item_in.entry_count   = ENTRY_COUNT_W'(count_ff);
               rsp_item_in.top_valid     = (count_ff != '0);
               rsp_item_in.top_key       = (count_ff != '0) ? KEY_FIELD_W'(top_ff) : '0;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // root copy tracks every write to entry zero
   assign top_in = (we && waddr == '0) ? wdata : top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      top_ff      <= top_in;
      taken_ff    <= taken_in;
      status_ff   <= status_in;
      rsp_item_ff <= rsp_item_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      we |-> (CNT_W'(waddr) < count_ff))
      else $error("store write outside the filled region");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.item.mode == MODE_PUSH && count_ff != CNT_W'(CAPACITY))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not grow the heap by one");

   a_result_only_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("result issued outside the finish step");

endmodule

### verif/binary_max_heap_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_test
// Drives push and extract items into the heap queue and checks every result
// against an in-bench heap model. Directed items cover the extremes, ties and
// the empty corner. Random bursts then swing the fill between empty and
// full. Both channels idle at random, except for one steady stretch.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_test;
   import bmhq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 30;
   localparam int RANDOM_ITEMS = 1800;
   localparam int IDLE_PCT     = 18;
   localparam int STEADY_FROM  = 4000;
   localparam int STEADY_TO    = 9000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   req_item_type req_item  = '0;
   logic         rsp_ready = 1'b0;

   bmhq_req_if req_if ();
   bmhq_rsp_if rsp_if ();

   assign req_if.valid = req_valid;
   assign req_if.item  = req_item;
   assign rsp_if.ready = rsp_ready;

   binary_max_heap_queue i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // in-bench copy of the heap
   key_type heap_keys [CAPACITY];
   int      heap_fill = 0;

   req_item_type req_pending [$];
   rsp_item_type rsp_expected [$];

   int req_total      = 0;
   int items_accepted = 0;
   int rsp_checked    = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int push_count     = 0;
   int full_drops     = 0;
   int extract_count  = 0;
   int empty_extracts = 0;
   int peak_fill      = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  rsp_expected.size());
         $display("binary_max_heap_queue test failed");
         $finish;
      end
   end

   function automatic bit take_break();
      if (cycle_count >= STEADY_FROM && cycle_count < STEADY_TO)
         return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   // apply one operation to the model heap and return the result it gives
   function automatic rsp_item_type heap_apply(req_item_type op);
      rsp_item_type r;
      key_type      tmp;
      int           pos;
      int           up;
      int           lc;
      int           rc;
      int           best;
      r = '0;
      if (op.mode == MODE_PUSH) begin
         push_count++;
         if (heap_fill >= CAPACITY) begin
            r.status = STATUS_FULL;
            full_drops++;
         end else begin
            heap_keys[heap_fill] = key_type'(op.key_in);
            pos = heap_fill;
            heap_fill++;
            while (pos != 0) begin
               up = (pos - 1) / 2;
               if (heap_keys[pos] <= heap_keys[up])
                  break;
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[up];
               heap_keys[up] = tmp;
               pos = up;
            end
         end
      end else begin
         extract_count++;
         if (heap_fill == 0) begin
            r.status = STATUS_EMPTY;
            empty_extracts++;
         end else begin
            r.extracted_key = KEY_FIELD_W'(heap_keys[0]);
            heap_fill--;
            heap_keys[0] = heap_keys[heap_fill];
            pos = 0;
            // ties stay with the left child
            while (pos < heap_fill) begin
               best = pos;
               lc = 2 * pos + 1;
               rc = 2 * pos + 2;
               if (lc < heap_fill && heap_keys[lc] > heap_keys[best])
                  best = lc;
               if (rc < heap_fill && heap_keys[rc] > heap_keys[best])
                  best = rc;
               if (best == pos)
                  break;
               tmp = heap_keys[pos];
               heap_keys[pos] = heap_keys[best];
               heap_keys[best] = tmp;
               pos = best;
            end
         end
      end
      if (heap_fill > peak_fill)
         peak_fill = heap_fill;
      r.entry_count = ENTRY_COUNT_W'(heap_fill);
      if (heap_fill != 0) begin
         r.top_key   = KEY_FIELD_W'(heap_keys[0]);
         r.top_valid = 1'b1;
      end
      return r;
   endfunction

   function automatic void compare_rsp(rsp_item_type want, rsp_item_type got);
      if (want.extracted_key !== got.extracted_key || want.status !== got.status ||
          want.entry_count !== got.entry_count || want.top_key !== got.top_key ||
          want.top_valid !== got.top_valid) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("result %0d mismatch: expected key %h status %0d count %0d top %h/%0b",
                     rsp_checked, want.extracted_key, want.status, want.entry_count,
                     want.top_key, want.top_valid);
            $display("   got key %h status %0d count %0d top %h/%0b",
                     got.extracted_key, got.status, got.entry_count, got.top_key,
                     got.top_valid);
         end
      end
   endfunction

   // driver: predicts on accept, then offers the next item unless it idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_if.ready) begin
            rsp_expected.insert(rsp_expected.size(), heap_apply(req_item));
            items_accepted <= items_accepted + 1;
         end
         if (!req_valid || req_if.ready) begin
            if (req_pending.size() != 0 && !take_break()) begin
               req_item  <= req_pending.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure and in-order checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_ready) begin
            if (rsp_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: key %h status %0d count %0d",
                           rsp_if.item.extracted_key, rsp_if.item.status,
                           rsp_if.item.entry_count);
            end else begin
               compare_rsp(rsp_expected.pop_front(), rsp_if.item);
            end
            rsp_checked <= rsp_checked + 1;
         end
         rsp_ready <= !take_break();
      end
   end

   function automatic void add_push(logic [KEY_FIELD_W-1:0] k);
      req_item_type it;
      it.mode   = MODE_PUSH;
      it.key_in = k;
      req_pending.insert(req_pending.size(), it);
   endfunction

   function automatic void add_extract();
      req_item_type it;
      it.mode   = MODE_EXTRACT;
      it.key_in = $urandom;  // ignored by the block
      req_pending.insert(req_pending.size(), it);
   endfunction

   function automatic logic [KEY_FIELD_W-1:0] pick_key();
      int sel;
      sel = $urandom_range(9);
      if (sel < 3)
         return $urandom_range(7);  // narrow range forces ties
      if (sel == 3) begin
         case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return 32'h0000_0001;
         endcase
      end
      return $urandom;
   endfunction

   initial begin
      int bias;
      int seg_len;
      int n;

      // directed: empty extract, last-key extract, extremes, ties, drain past empty
      add_extract();
      add_push('0);
      add_extract();
      add_push('1);
      add_push('0);
      add_push(32'd7);
      add_push(32'd7);
      add_push(32'd7);
      add_push(32'h8000_0000);
      add_push(32'd1);
      add_push(32'd7);
      repeat (4) add_extract();
      add_push(32'h5555_5555);
      add_push(32'hAAAA_AAAA);
      repeat (7) add_extract();

      // random bursts with a push bias per burst, pure bursts reach full and empty
      n = 0;
      while (n < RANDOM_ITEMS) begin
         case ($urandom_range(6))
            0: bias = 100;
            1: bias = 85;
            2: bias = 60;
            3: bias = 50;
            4: bias = 40;
            5: bias = 15;
            default: bias = 0;
         endcase
         if (bias == 100 || bias == 0)
            seg_len = $urandom_range(70, 90);
         else
            seg_len = $urandom_range(20, 90);
         repeat (seg_len) begin
            if ($urandom_range(99) < bias)
               add_push(pick_key());
            else
               add_extract();
            n++;
         end
      end
      req_total = req_pending.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted < req_total)
         @(posedge clock);
      while (rsp_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d pushes (%0d dropped when full), %0d extracts (%0d on empty),",
               push_count, full_drops, extract_count, empty_extracts);
      $display("peak fill %0d of %0d, %0d results checked, %0d mismatches",
               peak_fill, CAPACITY, rsp_checked, mismatch_count);
      if (mismatch_count == 0 && rsp_expected.size() == 0)
         $display("binary_max_heap_queue test passed");
      else
         $display("binary_max_heap_queue test failed");
      $finish;
   end

endmodule
